// ===== src/clahe_pkg.sv =====
package clahe_pkg;

    localparam int TILE_EDGE = 32;
    localparam int TILE_AREA = TILE_EDGE * TILE_EDGE;
    localparam int PIX_W = 12;
    localparam int BIN_W = 13;
    localparam int CLIP_W = 13;
    localparam int LEVEL_W = 8;
    localparam int LEVELS = 256;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 13'd64;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL = 8'd255;

endpackage

// ===== src/clahe_tile_equalise_lut_top.sv =====
// CLAHE tile mapping block, 8-bit grey levels, one tile at a time.
//
// Input transaction: pixel is taken at a clock edge where start is high and
// busy is low. Counting is a read-modify-write of the bin memory: read in idle,
// written back in the count state (busy is high in the write cycle).
//
// After the last pixel of the tile (TILE_EDGE^2 pixels) the block runs:
//   clip pass : sums the excess above clip_limit
//   cdf pass  : writes the cumulative sums, finds cdf_min and
//               clears the bin memory behind it
//   map pass  : per level read, load, 22-step serial divide by
//               the denominator, emit; a level below cdf_min skips the divide
// A group of four levels goes out on out_valid once its fourth level is emitted.
// busy stays high until the last group; results are a one-cycle strobe and
// the receiver cannot stall.
// Config transaction: cfg_valid/cfg_ready carry clip_limit; cfg_ready is low
// in the count write and the clip and cdf passes, so the last pixel's value holds.
// Reset: asynchronous, active low; clip_limit to 64, then a clearing pass
// over the whole bin memory with busy high.
module clahe_tile_equalise_lut_top
    import clahe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        pixel,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [12:0]       cfg_data,
    output logic              out_valid,
    output logic [5:0]        group_index,
    output logic [7:0]        map_level0,
    output logic [7:0]        map_level1,
    output logic [7:0]        map_level2,
    output logic [7:0]        map_level3,
    output logic              last_group
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_INC   = 4'd2;
    localparam logic [3:0] S_CLIP  = 4'd3;
    localparam logic [3:0] S_CDF   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam int NUM_W = 22;   // 2*8191*255 < 2^22
    localparam int DEN_W = 12;

    logic [BIN_W-1:0] bin_mem [LEVELS];
    logic [BIN_W-1:0] cdf_mem [LEVELS];

    logic [3:0]         state_reg, state_next;
    logic [8:0]         idx_reg, idx_next;
    logic [PIX_W-1:0]   pix_reg, pix_next;
    logic [CLIP_W-1:0]  clip_reg;
    logic [7:0]         inc_addr_reg;
    logic [BIN_W-1:0]   bin_q, cdf_q;
    logic [20:0]        excess_reg, excess_next;
    logic [BIN_W-1:0]   run_reg, run_next;
    logic [BIN_W-1:0]   prev_reg, prev_next;
    logic [BIN_W-1:0]   cmin_reg, cmin_next;
    logic               found_reg, found_next;
    logic [DEN_W:0]     den_reg, den_next;
    logic [BIN_W-1:0]   bonus_reg, bonus_next;
    logic [NUM_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [8:0]         quo_reg, quo_next;
    logic [4:0]         bit_reg, bit_next;
    logic [1:0]         lane_reg, lane_next;
    logic [7:0]         lv_reg [4];
    logic [7:0]         lv_next [4];

    // memory port controls
    logic               bin_we, cdf_we;
    logic [7:0]         bin_waddr, bin_raddr, cdf_addr;
    logic [BIN_W-1:0]   bin_wdata, cdf_wdata;

    logic [BIN_W-1:0]   clipped;
    logic [BIN_W-1:0]   cdf_val;
    logic [8:0]         eq_val;

    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[bin_waddr] <= bin_wdata;
        bin_q <= bin_mem[bin_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cdf_we)
            cdf_mem[cdf_addr] <= cdf_wdata;
        cdf_q <= cdf_mem[cdf_addr];
    end

    assign clipped = (bin_q > clip_reg) ? clip_reg : bin_q;
    assign cdf_val = run_reg + clipped + bonus_reg;
    assign eq_val  = (quo_reg > 9'd255) ? 9'd255 : quo_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        pix_next    = pix_reg;
        excess_next = excess_reg;
        run_next    = run_reg;
        prev_next   = prev_reg;
        cmin_next   = cmin_reg;
        found_next  = found_reg;
        den_next    = den_reg;
        bonus_next  = bonus_reg;
        rem_next    = rem_reg;
        num_next    = num_reg;
        quo_next    = quo_reg;
        bit_next    = bit_reg;
        lane_next   = lane_reg;
        for (int k = 0; k < 4; k++)
            lv_next[k] = lv_reg[k];
        bin_we    = 1'b0;
        bin_waddr = idx_reg[7:0];
        bin_wdata = '0;
        bin_raddr = idx_reg[7:0];
        cdf_we    = 1'b0;
        cdf_addr  = idx_reg[7:0];
        cdf_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                bin_we   = 1'b1;
                idx_next = idx_reg + 9'd1;
                if (idx_reg == 9'd255)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                bin_raddr = pixel;
                if (start)
                    state_next = S_INC;
            end
            S_INC:
            begin
                bin_we    = 1'b1;
                bin_waddr = inc_addr_reg;
                bin_wdata = bin_q + 13'd1;
                if (pix_reg == PIX_W'(TILE_AREA - 1))
                begin
                    pix_next    = '0;
                    idx_next    = '0;
                    excess_next = '0;
                    state_next  = S_CLIP;
                end
                else
                begin
                    pix_next   = pix_reg + PIX_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_CLIP:
            begin
                // read address idx, data of idx-1 valid when idx>0
                idx_next = idx_reg + 9'd1;
                if (idx_reg != 9'd0 && bin_q > clip_reg)
                    excess_next = excess_reg + 21'(bin_q - clip_reg);
                if (idx_reg == 9'd256)
                begin
                    idx_next   = '0;
                    run_next   = '0;
                    prev_next  = '0;
                    found_next = 1'b0;
                    cmin_next  = '0;
                    if (excess_next > 21'd256)
                    begin
                        bonus_next = 13'(excess_next >> 8);
                        den_next   = 13'(TILE_AREA) - 13'(excess_next[7:0]);
                    end
                    else
                    begin
                        bonus_next = '0;
                        den_next   = 13'(TILE_AREA);
                    end
                    excess_next = 21'(excess_next[7:0]);
                    state_next  = S_CDF;
                end
            end
            S_CDF:
            begin
                idx_next = idx_reg + 9'd1;
                if (idx_reg != 9'd0)
                begin
                    cdf_we    = 1'b1;
                    cdf_addr  = 8'(idx_reg - 9'd1);
                    cdf_wdata = cdf_val;
                    run_next  = cdf_val;
                    bin_we    = 1'b1;
                    bin_waddr = 8'(idx_reg - 9'd1);
                    prev_next = cdf_val;
                    if (!found_reg && idx_reg > 9'd1 && prev_reg == '0 && cdf_val != '0)
                    begin
                        found_next = 1'b1;
                        cmin_next  = cdf_val;
                    end
                end
                if (idx_reg == 9'd256)
                begin
                    if (den_reg == '0)
                        den_next = 13'd1;
                    idx_next   = '0;
                    lane_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (cdf_q < cmin_reg)
                begin
                    quo_next = 9'd255;
                    state_next = S_EMIT;
                end
                else
                begin
                    // 2*(cdf-cmin)*255 ; then add den: q=(2num+den)/(2den)
                    num_next = NUM_W'({9'd0, cdf_q - cmin_reg} * 22'd510)
                             + NUM_W'(den_reg);
                    rem_next = '0;
                    quo_next = '0;
                    bit_next = 5'(NUM_W - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = {rem_reg[NUM_W-2:0], num_reg[bit_reg]};
                if ({1'b0, rem_next} >= {{(NUM_W-DEN_W){1'b0}}, den_reg[DEN_W-1:0], 1'b0}
                    || den_reg[DEN_W])
                begin
                    if (!(den_reg[DEN_W] && {1'b0, rem_next} < 23'(TILE_AREA * 2)))
                    begin
                        rem_next = rem_next - NUM_W'({den_reg, 1'b0});
                        if (quo_reg < 9'd256)
                            quo_next = {quo_reg[7:0], 1'b1};
                        else
                            quo_next = 9'd256;
                    end
                    else
                        quo_next = (quo_reg >= 9'd128) ? 9'd256 : {quo_reg[7:0], 1'b0};
                end
                else
                    quo_next = (quo_reg >= 9'd128) ? 9'd256 : {quo_reg[7:0], 1'b0};
                if (bit_reg == 5'd0)
                    state_next = S_EMIT;
                else
                    bit_next = bit_reg - 5'd1;
            end
            S_EMIT:
            begin
                lv_next[lane_reg] = eq_val[7:0];
                lane_next = lane_reg + 2'd1;
                idx_next  = idx_reg + 9'd1;
                if (idx_reg == 9'd255)
                    state_next = S_IDLE;
                else
                    state_next = S_RD;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= '0;
            pix_reg   <= '0;
            clip_reg  <= CLIP_RESET;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pix_reg   <= pix_next;
            if (cfg_valid && cfg_ready)
                clip_reg <= cfg_data;
            out_valid <= (state_reg == S_EMIT) && (lane_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
            inc_addr_reg <= pixel;
        excess_reg <= excess_next;
        run_reg    <= run_next;
        prev_reg   <= prev_next;
        cmin_reg   <= cmin_next;
        found_reg  <= found_next;
        den_reg    <= den_next;
        bonus_reg  <= bonus_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        bit_reg    <= bit_next;
        lane_reg   <= lane_next;
        for (int k = 0; k < 4; k++)
            lv_reg[k] <= lv_next[k];
        if (state_reg == S_EMIT && lane_reg == 2'd3)
        begin
            group_index <= idx_reg[7:2];
            last_group  <= (idx_reg[7:2] == 6'd63);
        end
    end

    assign map_level0 = lv_reg[0];
    assign map_level1 = lv_reg[1];
    assign map_level2 = lv_reg[2];
    assign map_level3 = lv_reg[3];
    assign busy      = (state_reg != S_IDLE);
    // clip_limit is frozen from the last pixel's count write through the cdf pass
    assign cfg_ready = (state_reg != S_INC) && (state_reg != S_CLIP) && (state_reg != S_CDF);

endmodule

// ===== src/clahe_checker.sv =====
module clahe_checker
    import clahe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_valid,
    input logic last_group,
    input logic [5:0] group_index
);

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |=> !out_valid) else $error("strobe too long");

    a_last_is_63: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_group |-> group_index == 6'd63) else $error("bad last");

    a_busy_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_group |-> busy) else $error("idle mid map");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && group_index != 6'd0 |-> $past(busy)) else $error("order");

endmodule

bind clahe_tile_equalise_lut_top clahe_checker u_chk (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .out_valid(out_valid), .last_group(last_group), .group_index(group_index)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import clahe_pkg::*;

    typedef struct {
        logic [5:0] group;
        logic [7:0] lvl [4];
        logic       last;
    } map_group_t;

    localparam int NUM_TILES = 7;
    localparam int WATCHDOG_LIMIT = 20000;
    // cycles allowed after the last group before the next register write
    localparam int SETTLE_CYCLES = 20;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        pixel;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [12:0]       cfg_data;
    logic              out_valid;
    logic [5:0]        group_index;
    logic [7:0]        map_level0;
    logic [7:0]        map_level1;
    logic [7:0]        map_level2;
    logic [7:0]        map_level3;
    logic              last_group;

    // pixels waiting for the driver, and map groups waiting for the monitor
    logic [7:0]        pixel_q [$];
    map_group_t        map_q [$];

    // predictor state
    logic [CLIP_W-1:0] clip_now;
    logic [BIN_W-1:0]  hist [LEVELS];
    int                tile_fill;

    int                queued_cnt;
    int                taken_cnt;
    int                errors;
    int                quiet_cycles;
    bit                no_gaps;

    clahe_tile_equalise_lut_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .group_index (group_index),
        .map_level0  (map_level0),
        .map_level1  (map_level1),
        .map_level2  (map_level2),
        .map_level3  (map_level3),
        .last_group  (last_group)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Equalise one cumulative value: exact rounding, halves up, capped at 255.
    // A value below cdf_min would wrap negative and so lands on 255.
    function automatic logic [7:0] equalised_level(int cdf, int cdf_min, int den);
        int num;
        int q;
        if (cdf < cdf_min)
            return TOP_LEVEL;
        num = (cdf - cdf_min) * 255;
        q = (2 * num + den) / (2 * den);
        return (q > 255) ? TOP_LEVEL : q[7:0];
    endfunction

    // Clip, redistribute, accumulate and queue the 64 expected map groups.
    task automatic build_tile_map();
        int excess;
        int bonus;
        int lost;
        int run;
        int cdf_min;
        int den;
        int b;
        int cdf [LEVELS];
        map_group_t g;
        excess = 0;
        bonus = 0;
        lost = 0;
        run = 0;
        cdf_min = 0;
        for (int i = 0; i < LEVELS; i++)
            if (hist[i] > clip_now)
                excess += hist[i] - clip_now;
        // an excess of 256 or less is simply dropped
        if (excess > LEVELS)
        begin
            bonus = excess / LEVELS;
            lost = excess % LEVELS;
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            b = (hist[i] > clip_now) ? clip_now : hist[i];
            run += b + bonus;
            cdf[i] = run & 13'h1FFF;
        end
        for (int i = 1; i < LEVELS; i++)
            if (cdf[i-1] == 0 && cdf[i] != 0)
            begin
                cdf_min = cdf[i];
                break;
            end
        den = TILE_AREA - lost;
        if (den == 0)
            den = 1;
        for (int gi = 0; gi < LEVELS / 4; gi++)
        begin
            g.group = gi[5:0];
            for (int k = 0; k < 4; k++)
                g.lvl[k] = equalised_level(cdf[4*gi+k], cdf_min, den);
            g.last = (gi == LEVELS / 4 - 1);
            map_q.push_back(g);
        end
    endtask

    task automatic count_pixel(logic [7:0] p);
        hist[p] = hist[p] + BIN_W'(1);
        tile_fill++;
        if (tile_fill == TILE_AREA)
        begin
            build_tile_map();
            for (int i = 0; i < LEVELS; i++)
                hist[i] = '0;
            tile_fill = 0;
        end
    endtask

    // Driver: offers the next pixel, idling about 6% of cycles outside the
    // no-gap stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pixel <= '0;
        end
        else if (!start || !busy)
        begin
            if (pixel_q.size() > 0 && (no_gaps || $urandom_range(99) >= 6))
            begin
                start <= 1'b1;
                pixel <= pixel_q.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: feeds accepted pixels to the predictor, checks each map group,
    // and runs the watchdog on cycles where no transaction happens.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                count_pixel(pixel);
                taken_cnt++;
            end
            if (out_valid)
            begin
                if (map_q.size() == 0)
                begin
                    $display("%0t: unexpected map group %0d", $time, group_index);
                    errors++;
                end
                else
                begin
                    map_group_t e;
                    e = map_q.pop_front();
                    if (group_index !== e.group)
                    begin
                        $display("%0t: group_index exp %0d got %0d", $time, e.group, group_index);
                        errors++;
                    end
                    if (map_level0 !== e.lvl[0])
                    begin
                        $display("%0t: group %0d map_level0 exp %0d got %0d",
                                 $time, e.group, e.lvl[0], map_level0);
                        errors++;
                    end
                    if (map_level1 !== e.lvl[1])
                    begin
                        $display("%0t: group %0d map_level1 exp %0d got %0d",
                                 $time, e.group, e.lvl[1], map_level1);
                        errors++;
                    end
                    if (map_level2 !== e.lvl[2])
                    begin
                        $display("%0t: group %0d map_level2 exp %0d got %0d",
                                 $time, e.group, e.lvl[2], map_level2);
                        errors++;
                    end
                    if (map_level3 !== e.lvl[3])
                    begin
                        $display("%0t: group %0d map_level3 exp %0d got %0d",
                                 $time, e.group, e.lvl[3], map_level3);
                        errors++;
                    end
                    if (last_group !== e.last)
                    begin
                        $display("%0t: group %0d last_group exp %0d got %0d",
                                 $time, e.group, e.last, last_group);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // One register write; it waits for cfg_ready, and the first call runs during the reset clearing pass.
    task automatic write_clip(logic [12:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        clip_now = v;
        cfg_valid <= 1'b0;
    endtask

    // Queue one full tile of pixels shaped by kind.
    task automatic load_tile(int kind);
        logic [7:0] p;
        for (int i = 0; i < TILE_AREA; i++)
        begin
            case (kind)
                0:  begin
                        // extremes and a few spot levels first, then uniform
                        case (i)
                            0: p = 8'd0;
                            1: p = 8'd255;
                            2: p = 8'd1;
                            3: p = 8'd254;
                            4: p = 8'd128;
                            5: p = 8'd127;
                            6: p = 8'h55;
                            7: p = 8'hAA;
                            default: p = 8'($urandom_range(255));
                        endcase
                    end
                1:  p = 8'($urandom_range(90, 60));
                // two bins of 512 with clip 384: excess lands on exactly 256
                2:  p = (i % 2) ? 8'd37 : 8'd200;
                3:  p = 8'($urandom_range(150, 100));
                4:  p = 8'($urandom_range(255));
                5:  p = 8'd255;
                default: p = ($urandom_range(9) < 7) ? 8'($urandom_range(48, 40))
                                                     : 8'($urandom_range(255));
            endcase
            pixel_q.push_back(p);
            queued_cnt++;
        end
    endtask

    initial
    begin
        logic [12:0] clip_plan [NUM_TILES];
        clip_plan = '{13'd64, 13'd0, 13'd384, 13'd8191, 13'd1, 13'd4096, 13'd5};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        clip_now = CLIP_RESET;
        for (int i = 0; i < LEVELS; i++)
            hist[i] = '0;
        tile_fill = 0;
        queued_cnt = 0;
        taken_cnt = 0;
        errors = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int t = 0; t < NUM_TILES; t++)
        begin
            write_clip(clip_plan[t]);
            no_gaps = (t == 2);
            load_tile(t);
            // sender holds off until the whole map of this tile is out
            wait (taken_cnt == queued_cnt && map_q.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && map_q.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== clahe_tile_equalise_lut_top.f =====
src/clahe_pkg.sv
src/clahe_tile_equalise_lut_top.sv
src/clahe_checker.sv
tb/tb.sv
